// ===== rtl/sector_store_with_write_lock_top_macros.svh =====
// Assertion macros shared by the sector store RTL.
// Simulation gets concurrent assertions; synthesis builds see empty bodies.
`ifndef SECTOR_STORE_WITH_WRITE_LOCK_TOP_MACROS_SVH
`define SECTOR_STORE_WITH_WRITE_LOCK_TOP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SSWL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sswl assertion failed");
// next-cycle implication
`define SSWL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sswl assertion failed");
`else
`define SSWL_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SSWL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/sswl_pkg.sv =====
// Shared types and constants for the sector store with write lock.
// No dependencies; used by every module of the block except sswl_ram.
`default_nettype none
package sswl_pkg;

  localparam int SECTOR_COUNT_DEF     = 31;
  localparam int BYTES_PER_SECTOR_DEF = 8;
  localparam int SECTOR_W             = 8;
  localparam int DATA_W               = 64;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BAD_SECTOR = 2'd1,
    STATUS_LOCKED     = 2'd2
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // request accepted this cycle
    logic exec;     // stored data valid, finish request
  } ctl_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/sswl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sswl_ram #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 31,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== rtl/sswl_ctrl.sv =====
// Request sequencer: accept, execute state, result strobe.
// Depends on sswl_pkg and the assertion macro header.
`default_nettype none
`include "sector_store_with_write_lock_top_macros.svh"
module sswl_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  output logic                    out_valid,
  output sswl_pkg::ctl_cmd_t      cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign busy   = (state_r == ST_EXEC);
  assign accept = start && !busy;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign cmd.capture = accept;
  assign cmd.exec    = (state_r == ST_EXEC);
  assign out_valid   = out_valid_r;

  `SSWL_ASSERT_NEXT(a_accept_exec, clk, rst_n, accept, state_r == ST_EXEC)
  `SSWL_ASSERT_NEXT(a_exec_strobe, clk, rst_n, state_r == ST_EXEC, out_valid_r)
  `SSWL_ASSERT_NOW(a_strobe_idle, clk, rst_n, out_valid_r, !busy)

endmodule
`default_nettype wire

// ===== rtl/sswl_dpath.sv =====
// Datapath: request capture, sector RAM, lock bits and result registers.
// Depends on sswl_pkg, sswl_ram and the assertion macro header.
`default_nettype none
`include "sector_store_with_write_lock_top_macros.svh"
module sswl_dpath #(
  parameter int SECTOR_COUNT     = sswl_pkg::SECTOR_COUNT_DEF,
  parameter int BYTES_PER_SECTOR = sswl_pkg::BYTES_PER_SECTOR_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire sswl_pkg::ctl_cmd_t            cmd,
  input  wire logic                          in_mode,
  input  wire logic [sswl_pkg::SECTOR_W-1:0] in_sector,
  input  wire logic                          in_lock_request,
  input  wire logic [sswl_pkg::DATA_W-1:0]   in_write_data,
  output logic      [sswl_pkg::SECTOR_W-1:0] out_sector_echo,
  output logic                               out_is_locked,
  output logic      [sswl_pkg::DATA_W-1:0]   out_read_data,
  output logic      [1:0]                    out_status
);

  localparam int IDX_W = (SECTOR_COUNT > 1) ? $clog2(SECTOR_COUNT) : 1;
  localparam int DW    = 8 * BYTES_PER_SECTOR;
  localparam logic [sswl_pkg::SECTOR_W-1:0] SEC_LIMIT = sswl_pkg::SECTOR_W'(SECTOR_COUNT);

  // captured request (payload, no reset)
  logic                          req_mode_r;
  logic [sswl_pkg::SECTOR_W-1:0] req_sector_r;
  logic                          req_lock_r;
  logic [DW-1:0]                 req_wdata_r;

  // unlock bit per sector, written bit per RAM entry
  logic [SECTOR_COUNT-1:0] unlock_r, unlock_nxt;
  logic [SECTOR_COUNT-1:0] written_r, written_nxt;

  logic [sswl_pkg::SECTOR_W-1:0] echo_r;
  logic                          locked_out_r, locked_out_nxt;
  logic [sswl_pkg::DATA_W-1:0]   rdata_out_r, rdata_out_nxt;
  sswl_pkg::status_t             status_r, status_nxt;

  logic             rd_en;
  logic [IDX_W-1:0] idx;
  logic             sec_ok;
  logic             locked;
  logic             ram_we;
  logic [DW-1:0]    ram_rdata;
  logic [DW-1:0]    stored;

  assign rd_en  = cmd.capture && (in_sector < SEC_LIMIT);
  assign idx    = req_sector_r[IDX_W-1:0];
  assign sec_ok = (req_sector_r < SEC_LIMIT);
  assign locked = !unlock_r[idx];
  assign ram_we = cmd.exec && sec_ok && req_mode_r && !locked;
  // entries never written read as the erased pattern
  assign stored = written_r[idx] ? ram_rdata : '1;

  sswl_ram #(
    .WIDTH (DW),
    .DEPTH (SECTOR_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (req_wdata_r),
    .re    (rd_en),
    .raddr (in_sector[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    unlock_nxt     = unlock_r;
    written_nxt    = written_r;
    locked_out_nxt = 1'b0;
    rdata_out_nxt  = '0;
    status_nxt     = sswl_pkg::STATUS_OK;
    if (!sec_ok) begin
      status_nxt = sswl_pkg::STATUS_BAD_SECTOR;
    end else if (!req_mode_r) begin
      locked_out_nxt = locked;
      rdata_out_nxt  = sswl_pkg::DATA_W'(stored);
    end else if (locked) begin
      locked_out_nxt = 1'b1;
      status_nxt     = sswl_pkg::STATUS_LOCKED;
    end else begin
      written_nxt[idx] = 1'b1;
      if (req_lock_r) begin
        unlock_nxt[idx] = 1'b0;
      end
      locked_out_nxt = req_lock_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_mode_r   <= in_mode;
      req_sector_r <= in_sector;
      req_lock_r   <= in_lock_request;
      req_wdata_r  <= in_write_data[DW-1:0];
    end
    if (cmd.exec) begin
      echo_r       <= req_sector_r;
      locked_out_r <= locked_out_nxt;
      rdata_out_r  <= rdata_out_nxt;
      status_r     <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unlock_r  <= '1;
      written_r <= '0;
    end else if (cmd.exec) begin
      unlock_r  <= unlock_nxt;
      written_r <= written_nxt;
    end
  end

  assign out_sector_echo = echo_r;
  assign out_is_locked   = locked_out_r;
  assign out_read_data   = rdata_out_r;
  assign out_status      = status_r;

  `SSWL_ASSERT_NOW(a_we_unlocked, clk, rst_n, ram_we, unlock_r[idx] && sec_ok)
  `SSWL_ASSERT_NOW(a_lock_oneway, clk, rst_n, 1'b1, (unlock_r & ~$past(unlock_r)) == '0)
  `SSWL_ASSERT_NOW(a_no_capture_exec, clk, rst_n, cmd.exec, !cmd.capture)

endmodule
`default_nettype wire

// ===== rtl/sector_store_with_write_lock_top.sv =====
// Sector store with one-way write lock per sector (top level).
// Depends on sswl_pkg, sswl_ctrl, sswl_dpath and sswl_ram.
//
// Usage:
//   Input channel: drive in_mode (0 read, 1 write), in_sector, in_lock_request
//   and in_write_data with start high; the request is taken on a clock edge
//   where start is high and busy is low.
//   Result channel: out_valid is high for exactly one cycle with out_sector_echo,
//   out_is_locked, out_read_data and out_status (0 ok, 1 bad sector, 2 locked).
//   The receiver cannot stall; each result must be taken in its strobe cycle.
// Timing:
//   The sector RAM's registered read takes the accept cycle, the execute cycle
//   checks the lock and writes back, and the result strobe comes in the cycle
//   after that. busy is high only during the execute cycle, so no request is
//   accepted then, but a new request can be accepted while the previous result
//   is on the output ports.
// Reset:
//   rst_n (synchronous, active low) unlocks every sector at once and marks all
//   entries erased, so they read as all 0xFF bytes; no clearing pass is needed.
`default_nettype none
module sector_store_with_write_lock_top #(
  parameter int SECTOR_COUNT     = sswl_pkg::SECTOR_COUNT_DEF,
  parameter int BYTES_PER_SECTOR = sswl_pkg::BYTES_PER_SECTOR_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_mode,
  input  wire logic [sswl_pkg::SECTOR_W-1:0] in_sector,
  input  wire logic                          in_lock_request,
  input  wire logic [sswl_pkg::DATA_W-1:0]   in_write_data,
  output logic                               out_valid,
  output logic      [sswl_pkg::SECTOR_W-1:0] out_sector_echo,
  output logic                               out_is_locked,
  output logic      [sswl_pkg::DATA_W-1:0]   out_read_data,
  output logic      [1:0]                    out_status
);

  sswl_pkg::ctl_cmd_t cmd;

  sswl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  sswl_dpath #(
    .SECTOR_COUNT     (SECTOR_COUNT),
    .BYTES_PER_SECTOR (BYTES_PER_SECTOR)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_mode         (in_mode),
    .in_sector       (in_sector),
    .in_lock_request (in_lock_request),
    .in_write_data   (in_write_data),
    .out_sector_echo (out_sector_echo),
    .out_is_locked   (out_is_locked),
    .out_read_data   (out_read_data),
    .out_status      (out_status)
  );

endmodule
`default_nettype wire

// ===== tb/sector_store_with_write_lock_top_tb.sv =====
// Self-checking testbench for sector_store_with_write_lock_top.
// Depends on sswl_pkg and the block's RTL. A directed table runs first, then random requests.
// Results are checked against typed table rows or an in-bench model of store and lock bits.
`default_nettype none
module sector_store_with_write_lock_top_tb;
  import sswl_pkg::*;

  localparam logic       MODE_READ      = 1'b0;
  localparam logic       MODE_WRITE     = 1'b1;
  localparam int         NUM_SECTORS    = SECTOR_COUNT_DEF;
  localparam logic [63:0] DATA_ERASED   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] DATA_ZERO     = 64'h0;
  localparam int         RANDOM_ITEMS   = 1430;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         DRAIN_CYCLES   = 8;

  typedef struct packed {
    logic        mode;
    logic [7:0]  sector;
    logic        lock_req;
    logic [63:0] wdata;
  } sector_req_t;

  typedef struct packed {
    logic [7:0]  sector_echo;
    logic        is_locked;
    logic [63:0] rdata;
    status_t     status;
  } sector_resp_t;

  typedef struct packed {
    sector_req_t  req;
    logic         has_exp;
    sector_resp_t resp;
  } stim_row_t;

  localparam sector_resp_t NO_RESP = '0;

  // Typed results only where they follow straight from reset, range or lock rules.
  localparam int DIRECTED_N = 22;
  localparam stim_row_t DIRECTED_TBL [DIRECTED_N] = '{
    '{'{MODE_READ,  8'd0,   1'b0, DATA_ZERO},   1'b1, '{8'd0,   1'b0, DATA_ERASED, STATUS_OK}},
    '{'{MODE_READ,  8'd30,  1'b0, DATA_ZERO},   1'b1, '{8'd30,  1'b0, DATA_ERASED, STATUS_OK}},
    '{'{MODE_READ,  8'd31,  1'b0, DATA_ZERO},   1'b1, '{8'd31,  1'b0, DATA_ZERO, STATUS_BAD_SECTOR}},
    '{'{MODE_READ,  8'd255, 1'b1, DATA_ERASED}, 1'b1, '{8'd255, 1'b0, DATA_ZERO, STATUS_BAD_SECTOR}},
    '{'{MODE_WRITE, 8'd255, 1'b1, DATA_ERASED}, 1'b1, '{8'd255, 1'b0, DATA_ZERO, STATUS_BAD_SECTOR}},
    '{'{MODE_WRITE, 8'd128, 1'b0, DATA_ZERO},   1'b1, '{8'd128, 1'b0, DATA_ZERO, STATUS_BAD_SECTOR}},
    '{'{MODE_WRITE, 8'd0,   1'b0, DATA_ZERO},   1'b1, '{8'd0,   1'b0, DATA_ZERO, STATUS_OK}},
    '{'{MODE_READ,  8'd0,   1'b0, DATA_ERASED}, 1'b0, NO_RESP},
    '{'{MODE_WRITE, 8'd30,  1'b1, DATA_ERASED}, 1'b1, '{8'd30,  1'b1, DATA_ZERO, STATUS_OK}},
    '{'{MODE_READ,  8'd30,  1'b0, DATA_ZERO},   1'b0, NO_RESP},
    '{'{MODE_WRITE, 8'd30,  1'b0, DATA_ZERO},   1'b1, '{8'd30,  1'b1, DATA_ZERO, STATUS_LOCKED}},
    '{'{MODE_WRITE, 8'd30,  1'b1, DATA_ZERO},   1'b1, '{8'd30,  1'b1, DATA_ZERO, STATUS_LOCKED}},
    '{'{MODE_READ,  8'd5,   1'b1, DATA_ERASED}, 1'b0, NO_RESP},
    '{'{MODE_WRITE, 8'd5,   1'b0, 64'h0123_4567_89AB_CDEF}, 1'b0, NO_RESP},
    '{'{MODE_READ,  8'd5,   1'b0, DATA_ZERO},   1'b0, NO_RESP},
    '{'{MODE_WRITE, 8'd5,   1'b0, 64'hAAAA_AAAA_AAAA_AAAA}, 1'b0, NO_RESP},
    '{'{MODE_WRITE, 8'd1,   1'b0, 64'h5555_5555_5555_5555}, 1'b0, NO_RESP},
    '{'{MODE_READ,  8'd1,   1'b0, DATA_ZERO},   1'b0, NO_RESP},
    '{'{MODE_WRITE, 8'd16,  1'b1, 64'h8000_0000_0000_0001}, 1'b0, NO_RESP},
    '{'{MODE_READ,  8'd16,  1'b0, DATA_ZERO},   1'b0, NO_RESP},
    '{'{MODE_WRITE, 8'd16,  1'b0, DATA_ERASED}, 1'b0, NO_RESP},
    '{'{MODE_READ,  8'd15,  1'b0, DATA_ZERO},   1'b0, NO_RESP}
  };

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        start           = 1'b0;
  logic        in_mode         = 1'b0;
  logic [7:0]  in_sector       = '0;
  logic        in_lock_request = 1'b0;
  logic [63:0] in_write_data   = '0;
  wire         busy;
  wire         out_valid;
  wire [7:0]   out_sector_echo;
  wire         out_is_locked;
  wire [63:0]  out_read_data;
  wire [1:0]   out_status;

  sector_store_with_write_lock_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_sector       (in_sector),
    .in_lock_request (in_lock_request),
    .in_write_data   (in_write_data),
    .out_valid       (out_valid),
    .out_sector_echo (out_sector_echo),
    .out_is_locked   (out_is_locked),
    .out_read_data   (out_read_data),
    .out_status      (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mirror of the store
  logic [63:0]            sector_mirror [NUM_SECTORS];
  logic [NUM_SECTORS-1:0] unlock_mirror;

  stim_row_t    request_q [$];
  sector_resp_t expected_q [$];
  int unsigned  send_idx    = 0;
  int unsigned  gap_left    = 0;
  int unsigned  burst_left  = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  err_cnt     = 0;
  int unsigned  n_results   = 0;
  int unsigned  n_reads     = 0;
  int unsigned  n_writes    = 0;
  int unsigned  n_bad       = 0;
  int unsigned  n_refused   = 0;
  int unsigned  n_locks     = 0;

  function automatic void clear_mirror();
    for (int i = 0; i < NUM_SECTORS; i++) sector_mirror[i] = DATA_ERASED;
    unlock_mirror = '1;
  endfunction

  // Applies one request to the mirror and returns the response it should give.
  function automatic void predict_sector_access(input sector_req_t req,
                                                output sector_resp_t resp);
    logic was_locked;
    resp             = NO_RESP;
    resp.sector_echo = req.sector;
    resp.status      = STATUS_OK;
    if (req.sector >= NUM_SECTORS) begin
      resp.status = STATUS_BAD_SECTOR;
      n_bad++;
    end else begin
      was_locked = !unlock_mirror[req.sector];
      if (req.mode == MODE_READ) begin
        resp.is_locked = was_locked;
        resp.rdata     = sector_mirror[req.sector];
        n_reads++;
      end else if (was_locked) begin
        resp.is_locked = 1'b1;
        resp.status    = STATUS_LOCKED;
        n_refused++;
      end else begin
        sector_mirror[req.sector] = req.wdata;
        if (req.lock_req) begin
          unlock_mirror[req.sector] = 1'b0;
          n_locks++;
        end
        resp.is_locked = req.lock_req;
        n_writes++;
      end
    end
  endfunction

  // mostly short gaps, some long, and bursts with none
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin : request_driver
    sector_resp_t predicted;
    logic         drive_start;
    drive_start = 1'b0;
    if (rst_n) begin
      if (start && !busy) begin
        predict_sector_access(request_q[send_idx].req, predicted);
        expected_q.push_back(request_q[send_idx].has_exp ? request_q[send_idx].resp : predicted);
        send_idx++;
        gap_left = pick_gap();
      end
      if (start && busy) begin
        drive_start = 1'b1;  // hold the request until taken
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (send_idx < request_q.size()) begin
        drive_start     = 1'b1;
        in_mode         <= request_q[send_idx].req.mode;
        in_sector       <= request_q[send_idx].req.sector;
        in_lock_request <= request_q[send_idx].req.lock_req;
        in_write_data   <= request_q[send_idx].req.wdata;
      end
    end
    start <= drive_start;
  end

  always @(posedge clk) begin : result_check
    sector_resp_t exp_r;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result for sector %0d with nothing expected", $time, out_sector_echo);
        err_cnt++;
      end else begin
        exp_r = expected_q.pop_front();
        n_results++;
        if (out_sector_echo !== exp_r.sector_echo) begin
          $display("%0t: sector_echo expected %0d got %0d", $time, exp_r.sector_echo,
                   out_sector_echo);
          err_cnt++;
        end
        if (out_is_locked !== exp_r.is_locked) begin
          $display("%0t: is_locked (sector %0d) expected %0d got %0d", $time,
                   exp_r.sector_echo, exp_r.is_locked, out_is_locked);
          err_cnt++;
        end
        if (out_read_data !== exp_r.rdata) begin
          $display("%0t: read_data (sector %0d) expected %h got %h", $time,
                   exp_r.sector_echo, exp_r.rdata, out_read_data);
          err_cnt++;
        end
        if (out_status !== exp_r.status) begin
          $display("%0t: status (sector %0d) expected %0d got %0d", $time,
                   exp_r.sector_echo, exp_r.status, out_status);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: %0d requests sent, %0d results pending", send_idx, expected_q.size());
      $display("FAIL sector_store_with_write_lock_top");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : main_seq
    stim_row_t   row;
    int unsigned roll;
    int unsigned hot_base;
    clear_mirror();
    hot_base = 0;
    for (int i = 0; i < DIRECTED_N; i++) request_q.push_back(DIRECTED_TBL[i]);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      row = '0;
      if (i % 100 == 0) hot_base = $urandom_range(0, NUM_SECTORS - 4);
      roll = $urandom_range(0, 99);
      // hot window keeps read-after-write and lock hits frequent
      if (roll < 10)      row.req.sector = 8'($urandom_range(NUM_SECTORS, 255));
      else if (roll < 12) row.req.sector = 8'(NUM_SECTORS);
      else if (roll < 14) row.req.sector = 8'd255;
      else if (roll < 55) row.req.sector = 8'(hot_base + $urandom_range(0, 3));
      else                row.req.sector = 8'($urandom_range(0, NUM_SECTORS - 1));
      row.req.mode = 1'($urandom_range(0, 1));
      if (row.req.mode == MODE_WRITE) row.req.lock_req = ($urandom_range(0, 39) == 0);
      else                            row.req.lock_req = 1'($urandom_range(0, 1));
      roll = $urandom_range(0, 99);
      if (roll < 5)       row.req.wdata = DATA_ZERO;
      else if (roll < 10) row.req.wdata = DATA_ERASED;
      else                row.req.wdata = {$urandom, $urandom};
      request_q.push_back(row);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (!(send_idx == request_q.size() && expected_q.size() == 0)) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);

    $display("run covered %0d requests, %0d results checked: %0d reads, %0d writes",
             send_idx, n_results, n_reads, n_writes);
    $display("  %0d bad sector numbers, %0d writes refused as locked, %0d sectors locked",
             n_bad, n_refused, n_locks);
    if (err_cnt == 0) begin
      $display("PASS sector_store_with_write_lock_top");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("FAIL sector_store_with_write_lock_top");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/sswl_pkg.sv
rtl/sswl_ram.sv
rtl/sswl_ctrl.sv
rtl/sswl_dpath.sv
rtl/sector_store_with_write_lock_top.sv
tb/sector_store_with_write_lock_top_tb.sv
